// ===== rtl/core/lru_handle_cache_macros.svh =====
// assertion macros for the lru handle cache rtl
`ifndef LRU_HANDLE_CACHE_MACROS_SVH
`define LRU_HANDLE_CACHE_MACROS_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define LHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, same clock and reset
`define LHC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lhc_pkg.sv =====
// shared types and widths for the lru handle cache
`timescale 1ns / 1ps
`default_nettype none

package lhc_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SLOT_W   = 4;

  // search token that walks down the row of entry cells
  typedef struct packed {
    logic                active;
    logic [KEY_W-1:0]    key;
    logic                match;
    logic                free;
    logic                min_vld;
    logic [HANDLE_W-1:0] match_handle;
    logic [KEY_W-1:0]    min_key;
    logic [HANDLE_W-1:0] min_handle;
    logic [STAMP_W-1:0]  min_stamp;
  } scan_t;

  // entry update broadcast to all cells
  typedef struct packed {
    logic                en;
    logic                fill;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/core/lhc_cell.sv =====
// one table entry plus one stage of the search token chain
`timescale 1ns / 1ps
`default_nettype none

module lhc_cell import lhc_pkg::*; #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scan_t            scan_i,
  input  wire logic [IDX_W-1:0] match_idx_i,
  input  wire logic [IDX_W-1:0] free_idx_i,
  input  wire logic [IDX_W-1:0] min_idx_i,
  output scan_t                 scan_o,
  output logic      [IDX_W-1:0] match_idx_o,
  output logic      [IDX_W-1:0] free_idx_o,
  output logic      [IDX_W-1:0] min_idx_o,
  input  wire upd_t             upd_i,
  input  wire logic [IDX_W-1:0] upd_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                valid_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [STAMP_W-1:0]  stamp_q;

  scan_t               scan_d, scan_q;
  logic [IDX_W-1:0]    midx_d, midx_q;
  logic [IDX_W-1:0]    fidx_d, fidx_q;
  logic [IDX_W-1:0]    nidx_d, nidx_q;
  logic                upd_me;

  assign upd_me = upd_i.en && (upd_idx_i == MY_IDX);

  // fold this entry into the passing token
  always_comb begin
    scan_d = scan_i;
    midx_d = match_idx_i;
    fidx_d = free_idx_i;
    nidx_d = min_idx_i;
    if (scan_i.active) begin
      if (valid_q && (key_q == scan_i.key) && !scan_i.match) begin
        scan_d.match        = 1'b1;
        scan_d.match_handle = handle_q;
        midx_d              = MY_IDX;
      end
      if (!valid_q && !scan_i.free) begin
        scan_d.free = 1'b1;
        fidx_d      = MY_IDX;
      end
      // strict less-than keeps the lowest index on ties
      if (!scan_i.min_vld || (stamp_q < scan_i.min_stamp)) begin
        scan_d.min_vld    = 1'b1;
        scan_d.min_stamp  = stamp_q;
        scan_d.min_key    = key_q;
        scan_d.min_handle = handle_q;
        nidx_d            = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (upd_me && upd_i.fill) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    midx_q <= midx_d;
    fidx_q <= fidx_d;
    nidx_q <= nidx_d;
    if (upd_me) begin
      stamp_q <= upd_i.stamp;
      if (upd_i.fill) begin
        key_q    <= upd_i.key;
        handle_q <= upd_i.handle;
      end
    end
  end

  assign scan_o      = scan_q;
  assign match_idx_o = midx_q;
  assign free_idx_o  = fidx_q;
  assign min_idx_o   = nidx_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_handle_cache.sv =====
// lru handle cache: fully associative key-to-handle table, chain of entry cells
//
// input channel (in_valid_i / in_ready_o) carries lookup_key_i and new_handle_i;
// output channel (out_valid_o / out_ready_i) carries one result per input transfer
// an input transfer injects a search token into cell 0; the result is registered in
// fin_q once the token leaves the last cell, then loaded into the output register; the
// search token walks one entry cell per cycle down the chain; requests are handled one at a time
// a hit refreshes the entry stamp; a miss fills the lowest free entry, or evicts
// the entry with the smallest stamp (lowest index on ties) and reports it
// reset clears all valid bits, the use counter and the output valid flag;
// entries need no clearing pass, an invalid entry never matches
// a stalled receiver holds the result in the output register; the next request
// is still taken and searched, and its result waits until the output frees up
`timescale 1ns / 1ps
`default_nettype none

`include "lru_handle_cache_macros.svh"

module lru_handle_cache import lhc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [KEY_W-1:0]    lookup_key_i,
  input  wire logic [HANDLE_W-1:0] new_handle_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     hit_o,
  output logic [SLOT_W-1:0]        slot_index_o,
  output logic [HANDLE_W-1:0]      handle_out_o,
  output logic                     evicted_o,
  output logic [KEY_W-1:0]         evicted_key_o,
  output logic [HANDLE_W-1:0]      evicted_handle_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                evicted;
    logic [KEY_W-1:0]    ev_key;
    logic [HANDLE_W-1:0] ev_handle;
  } res_t;

  state_e               state_d, state_q;
  logic [STAMP_W-1:0]   cnt_q;
  logic [HANDLE_W-1:0]  nh_q;
  res_t                 res_c, fin_q, out_q;
  logic                 out_valid_q;
  logic                 in_xfer;
  logic                 scan_done;
  logic                 out_load;

  // token chain wiring: element i is the output of cell i
  scan_t                tok   [ENTRIES];
  logic [IDX_W-1:0]     midx  [ENTRIES];
  logic [IDX_W-1:0]     fidx  [ENTRIES];
  logic [IDX_W-1:0]     nidx  [ENTRIES];
  logic [ENTRIES-1:0]   tok_act;
  scan_t                inject;
  upd_t                 upd;
  logic [IDX_W-1:0]     upd_idx;
  logic [IDX_W-1:0]     tgt_idx;
  scan_t                last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // fresh token enters cell 0 on the input transfer
  always_comb begin
    inject        = '0;
    inject.active = in_xfer;
    inject.key    = lookup_key_i;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      lhc_cell #(.IDX_W(IDX_W), .IDX(i)) u_cell (
        .clk_i,
        .rst_ni,
        .scan_i      (inject),
        .match_idx_i ('0),
        .free_idx_i  ('0),
        .min_idx_i   ('0),
        .scan_o      (tok[i]),
        .match_idx_o (midx[i]),
        .free_idx_o  (fidx[i]),
        .min_idx_o   (nidx[i]),
        .upd_i       (upd),
        .upd_idx_i   (upd_idx)
      );
    end else begin : g_body
      lhc_cell #(.IDX_W(IDX_W), .IDX(i)) u_cell (
        .clk_i,
        .rst_ni,
        .scan_i      (tok[i-1]),
        .match_idx_i (midx[i-1]),
        .free_idx_i  (fidx[i-1]),
        .min_idx_i   (nidx[i-1]),
        .scan_o      (tok[i]),
        .match_idx_o (midx[i]),
        .free_idx_o  (fidx[i]),
        .min_idx_o   (nidx[i]),
        .upd_i       (upd),
        .upd_idx_i   (upd_idx)
      );
    end
    assign tok_act[i] = tok[i].active;
  end

  assign last      = tok[ENTRIES-1];
  assign scan_done = last.active && (state_q == ST_SCAN);

  // decide target entry once the token leaves the last cell
  always_comb begin
    if (last.match) begin
      tgt_idx = midx[ENTRIES-1];
    end else if (last.free) begin
      tgt_idx = fidx[ENTRIES-1];
    end else begin
      tgt_idx = nidx[ENTRIES-1];
    end

    res_c           = '0;
    res_c.hit       = last.match;
    res_c.slot      = SLOT_W'(tgt_idx);
    res_c.handle    = last.match ? last.match_handle : nh_q;
    res_c.evicted   = !last.match && !last.free;
    if (res_c.evicted) begin
      res_c.ev_key    = last.min_key;
      res_c.ev_handle = last.min_handle;
    end

    // hit only refreshes the stamp, miss rewrites the whole entry
    upd        = '0;
    upd.en     = scan_done;
    upd.fill   = !last.match;
    upd.key    = last.key;
    upd.handle = nh_q;
    upd.stamp  = cnt_q;
    upd_idx    = tgt_idx;
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // counter bumps per request, stamp is the bumped value
      if (in_xfer) begin
        cnt_q <= cnt_q + STAMP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      nh_q <= new_handle_i;
    end
    if (scan_done) begin
      fin_q <= res_c;
    end
    if (out_load) begin
      out_q <= fin_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_q.hit;
  assign slot_index_o     = out_q.slot;
  assign handle_out_o     = out_q.handle;
  assign evicted_o        = out_q.evicted;
  assign evicted_key_o    = out_q.ev_key;
  assign evicted_handle_o = out_q.ev_handle;

  // only one search token may ever be in flight
  `LHC_ASSERT(a_one_token, $onehot0(tok_act), "more than one search token in the chain")
  // chain is empty whenever a new request may enter
  `LHC_ASSERT_IMPL(a_idle_empty, state_q == ST_IDLE, tok_act == '0, "token left over in idle")
  // a hit never reports an eviction
  `LHC_ASSERT_IMPL(a_hit_no_ev, out_valid_o && hit_o, !evicted_o, "eviction reported on a hit")
  // without eviction the evicted fields read zero
  `LHC_ASSERT_IMPL(a_ev_zero, out_valid_o && !evicted_o,
    evicted_key_o == '0 && evicted_handle_o == '0, "stale evicted fields")

endmodule

`default_nettype wire

// ===== tb/lru_handle_checker.sv =====
// scoreboard for the lru handle cache: predicts every lookup and checks its result
`timescale 1ns / 1ps

module lru_handle_checker import lhc_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [KEY_W-1:0]    lookup_key_i,
  input  logic [HANDLE_W-1:0] new_handle_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                hit_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  input  logic [HANDLE_W-1:0] handle_out_i,
  input  logic                evicted_i,
  input  logic [KEY_W-1:0]    evicted_key_i,
  input  logic [HANDLE_W-1:0] evicted_handle_i,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                evicted;
    logic [KEY_W-1:0]    victim_key;
    logic [HANDLE_W-1:0] victim_handle;
  } lookup_result_t;

  // shadow copy of the table
  logic                tbl_valid  [ENTRIES];
  logic [KEY_W-1:0]    tbl_key    [ENTRIES];
  logic [HANDLE_W-1:0] tbl_handle [ENTRIES];
  logic [STAMP_W-1:0]  tbl_stamp  [ENTRIES];
  logic [STAMP_W-1:0]  use_count;

  lookup_result_t lookup_results_q [$];

  function automatic lookup_result_t predict_lookup(input logic [KEY_W-1:0] key,
                                                    input logic [HANDLE_W-1:0] handle);
    lookup_result_t res;
    int found;
    int vacant;
    int target;
    res = '0;
    found = -1;
    vacant = -1;
    use_count = use_count + 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && found < 0) found = i;
      if (!tbl_valid[i] && vacant < 0) vacant = i;
    end
    if (found >= 0) begin
      tbl_stamp[found] = use_count;
      res.hit = 1'b1;
      res.slot = SLOT_W'(found);
      res.handle = tbl_handle[found];
      return res;
    end
    if (vacant >= 0) begin
      target = vacant;
    end else begin
      // oldest stamp is evicted, the lowest index on a tie
      target = 0;
      for (int i = 1; i < ENTRIES; i++) begin
        if (tbl_stamp[i] < tbl_stamp[target]) target = i;
      end
      res.evicted = 1'b1;
      res.victim_key = tbl_key[target];
      res.victim_handle = tbl_handle[target];
    end
    tbl_valid[target] = 1'b1;
    tbl_key[target] = key;
    tbl_handle[target] = handle;
    tbl_stamp[target] = use_count;
    res.slot = SLOT_W'(target);
    res.handle = handle;
    return res;
  endfunction

  function automatic int unsigned field_differs(input string field,
                                                input logic [KEY_W-1:0] want,
                                                input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    lookup_result_t want;
    int unsigned bad;
    bad = 0;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_key[i] = '0;
        tbl_handle[i] = '0;
        tbl_stamp[i] = '0;
      end
      use_count = '0;
      lookup_results_q.delete();
    end else begin
      // results leave before the new lookup is predicted
      if (out_valid_i && out_ready_i) begin
        if (lookup_results_q.size() == 0) begin
          $error("result transfer with no lookup outstanding");
          bad++;
        end else begin
          want = lookup_results_q.pop_front();
          bad += field_differs("hit", want.hit, hit_i);
          bad += field_differs("slot_index", want.slot, slot_index_i);
          bad += field_differs("handle_out", want.handle, handle_out_i);
          bad += field_differs("evicted", want.evicted, evicted_i);
          bad += field_differs("evicted_key", want.victim_key, evicted_key_i);
          bad += field_differs("evicted_handle", want.victim_handle, evicted_handle_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        lookup_results_q.push_back(predict_lookup(lookup_key_i, new_handle_i));
      end
    end
    mismatches_o <= mismatches_o + bad;
    outstanding_o <= lookup_results_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for the lru handle cache: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
  import lhc_pkg::*;

  localparam int unsigned ENTRIES        = 16;
  localparam int unsigned PHASE_ITEMS    = 430;
  // long receiver hold-off, far beyond the request turnaround, so the block backs up
  localparam int unsigned HOLD_CYCLES    = 300;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // drain time after the last result
  localparam int unsigned DRAIN_CYCLES   = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [KEY_W-1:0]    lookup_key_i = '0;
  logic [HANDLE_W-1:0] new_handle_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                hit_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic                evicted_o;
  logic [KEY_W-1:0]    evicted_key_o;
  logic [HANDLE_W-1:0] evicted_handle_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // idle rates in percent per cycle, changed between phases
  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 62;
  logic        squeeze_req = 1'b0;
  logic        squeeze_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // keys reused so the table sees hits, fills and evictions
  logic [KEY_W-1:0] key_pool [40];

  lru_handle_cache #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .lookup_key_i     (lookup_key_i),
    .new_handle_i     (new_handle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .slot_index_o     (slot_index_o),
    .handle_out_o     (handle_out_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o),
    .evicted_handle_o (evicted_handle_o)
  );

  lru_handle_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .lookup_key_i     (lookup_key_i),
    .new_handle_i     (new_handle_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_i            (hit_o),
    .slot_index_i     (slot_index_o),
    .handle_out_i     (handle_out_o),
    .evicted_i        (evicted_o),
    .evicted_key_i    (evicted_key_o),
    .evicted_handle_i (evicted_handle_o),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // receiver side: random stalls, plus one long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hang detection: any transfer on either channel resets the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one lookup and hold it until the transfer; returns just after the
  // accepting edge so the next call can keep valid high without a gap
  task automatic send_lookup(input logic [KEY_W-1:0] key, input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    lookup_key_i <= key;
    new_handle_i <= handle;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int unsigned span;
    logic [KEY_W-1:0] key;

    for (int i = 0; i < 40; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key zero, all-ones key, extreme handles
    send_lookup(32'h0000_0000, 16'hFFFF);
    send_lookup(32'hFFFF_FFFF, 16'h0000);
    // hit on key zero, the offered handle must be ignored
    send_lookup(32'h0000_0000, 16'h1234);
    // fill the rest of the table with free-entry misses
    for (int k = 1; k <= 14; k++) send_lookup(KEY_W'(k), HANDLE_W'($urandom_range(0, 65535)));
    send_lookup(32'hFFFF_FFFF, 16'h5A5A);
    // table full now: each new key evicts the oldest stamp
    send_lookup(32'h8000_0000, 16'h8000);
    send_lookup(32'h7FFF_FFFF, 16'h7FFF);
    // an evicted key comes back as a miss
    send_lookup(32'h0000_0001, 16'h0001);

    // random phases: sender idles lightly, then heavily, then never
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          span = 20;
        end
        1: begin
          span = 36;
          tx_idle_pct <= 62;
          rx_idle_pct <= 23;
        end
        default: begin
          span = 17;
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
          squeeze_req <= 1'b1;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly pooled keys for hit and eviction traffic, some fresh keys
        if ($urandom_range(99) < 80) key = key_pool[$urandom_range(0, span - 1)];
        else key = $urandom;
        send_lookup(key, HANDLE_W'($urandom_range(0, 65535)));
      end
    end
    in_valid_i <= 1'b0;

    // wait for every outstanding result, then let the block settle
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
